### sv/lqa_pkg.sv
// Shared types and constants for the look-at quaternion core.
package lqa_pkg;

  localparam int UFRAC = 30;
  localparam int UW    = UFRAC + 2;

  localparam logic [1:0] BR_W = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lqa_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } lqa_out_t;

endpackage

### sv/lqa_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module lqa_isqrt #(
  parameter int VW = 64,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [VW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [VW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);
  localparam int RW = VW / 2;
  localparam int XW = VW + 2;

  logic          vld_q  [RW];
  logic [XW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int B = RW - 1 - k;
    logic          vld_in;
    logic [XW-1:0] rem_in;
    logic [XW-1:0] trial;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = XW'(rad_i);
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = (XW'(root_in) << (B + 1)) | (XW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

### sv/lqa_div.sv
// Pipelined restoring divider, shared divisor over lanes, saturating quotient.
module lqa_div #(
  parameter int LANES = 3,
  parameter int NW    = 63,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int SW    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);
  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic                     p_vld_q;
  logic [LANES-1:0][CW-1:0] p_rem_q;
  logic [LANES-1:0]         p_ovf_q;
  logic [LANES-1:0]         p_ovf_d;
  logic [DW-1:0]            p_den_q;
  logic [SW-1:0]            p_side_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p_ovf_d[l] = CW'(num_i[l]) >= (CW'(den_i) << QW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        p_rem_q[l] <= CW'(num_i[l]);
      end
      p_ovf_q  <= p_ovf_d;
      p_den_q  <= den_i;
      p_side_q <= side_i;
    end
  end

  logic                     vld_q  [QW];
  logic [LANES-1:0][CW-1:0] rem_q  [QW];
  logic [LANES-1:0][QW-1:0] quo_q  [QW];
  logic [LANES-1:0]         ovf_q  [QW];
  logic [DW-1:0]            den_q  [QW];
  logic [SW-1:0]            side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int B = QW - 1 - k;
    logic                     vld_in;
    logic [LANES-1:0][CW-1:0] rem_in;
    logic [LANES-1:0][QW-1:0] quo_in;
    logic [LANES-1:0]         ovf_in;
    logic [DW-1:0]            den_in;
    logic [SW-1:0]            side_in;
    logic [CW-1:0]            sub;

    if (k == 0) begin : g_first
      assign vld_in  = p_vld_q;
      assign rem_in  = p_rem_q;
      assign quo_in  = '0;
      assign ovf_in  = p_ovf_q;
      assign den_in  = p_den_q;
      assign side_in = p_side_q;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign sub = CW'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[k]  <= ovf_in;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          if (rem_in[l] >= sub) begin
            rem_q[k][l] <= rem_in[l] - sub;
            quo_q[k][l] <= quo_in[l] | (QW'(1) << B);
          end else begin
            rem_q[k][l] <= rem_in[l];
            quo_q[k][l] <= quo_in[l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = ovf_q[QW-1][l] ? '1 : quo_q[QW-1][l];
    end
  end

  assign valid_o = vld_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### sv/lqa_unit.sv
// Pipelined 3-vector normalizer giving signed Q2.30 unit components.
module lqa_unit #(
  parameter int IW = 33,
  parameter int SW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][IW-1:0]            vec_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [2:0][lqa_pkg::UW-1:0]   unit_o,
  output logic [SW-1:0]                 side_o
);
  localparam int UF  = lqa_pkg::UFRAC;
  localparam int UW  = lqa_pkg::UW;
  localparam int PBW = $clog2(IW);
  localparam int RSW = SW + 4 + 3 * UF;
  localparam int DSW = SW + 4;
  localparam logic [PBW-1:0] TGT = PBW'(UF - 1);

  // magnitudes
  logic                  u1_vld_q;
  logic [2:0][IW-1:0]    u1_m_q;
  logic [2:0]            u1_sgn_q;
  logic [SW-1:0]         u1_side_q;
  // leading one
  logic                  u2_vld_q;
  logic [2:0][IW-1:0]    u2_m_q;
  logic [2:0]            u2_sgn_q;
  logic                  u2_zero_q;
  logic [PBW-1:0]        u2_pos_q;
  logic [SW-1:0]         u2_side_q;
  logic [IW-1:0]         or_m;
  logic [PBW-1:0]        pos_d;
  // normalized
  logic                  u3_vld_q;
  logic [2:0][UF-1:0]    u3_n_q;
  logic [2:0][UF-1:0]    n_d;
  logic [2:0]            u3_sgn_q;
  logic                  u3_zero_q;
  logic [SW-1:0]         u3_side_q;
  // squares
  logic                  u4_vld_q;
  logic [2:0][2*UF-1:0]  u4_sq_q;
  logic [2:0][UF-1:0]    u4_n_q;
  logic [2:0]            u4_sgn_q;
  logic                  u4_zero_q;
  logic [SW-1:0]         u4_side_q;
  // sum
  logic                  u5_vld_q;
  logic [2*UF+1:0]       u5_sum_q;
  logic [2:0][UF-1:0]    u5_n_q;
  logic [2:0]            u5_sgn_q;
  logic                  u5_zero_q;
  logic [SW-1:0]         u5_side_q;
  // root
  logic                  r_vld;
  logic [UF:0]           r_len;
  logic [RSW-1:0]        r_side;
  logic [SW-1:0]         r_uside;
  logic [2:0]            r_sgn;
  logic                  r_zero;
  logic [2:0][UF-1:0]    r_n;
  // divide setup
  logic                  u6_vld_q;
  logic [2:0][2*UF:0]    u6_num_q;
  logic [UF:0]           u6_den_q;
  logic [DSW-1:0]        u6_side_q;
  // quotient
  logic                  d_vld;
  logic [2:0][UF:0]      d_quo;
  logic [DSW-1:0]        d_side;
  logic [SW-1:0]         d_uside;
  logic [2:0]            d_sgn;
  logic                  d_zero;
  logic [2:0][UW-1:0]    unit_d;
  // output
  logic                  u7_vld_q;
  logic [2:0][UW-1:0]    u7_unit_q;
  logic [SW-1:0]         u7_side_q;

  always_comb begin
    or_m  = u1_m_q[0] | u1_m_q[1] | u1_m_q[2];
    pos_d = '0;
    for (int i = 0; i < IW; i++) begin
      if (or_m[i]) begin
        pos_d = PBW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (u2_pos_q >= TGT) begin
        n_d[i] = UF'({{UF{1'b0}}, u2_m_q[i]} >> (u2_pos_q - TGT));
      end else begin
        n_d[i] = UF'({{UF{1'b0}}, u2_m_q[i]} << (TGT - u2_pos_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_vld_q <= 1'b0;
      u2_vld_q <= 1'b0;
      u3_vld_q <= 1'b0;
      u4_vld_q <= 1'b0;
      u5_vld_q <= 1'b0;
      u6_vld_q <= 1'b0;
      u7_vld_q <= 1'b0;
    end else if (en_i) begin
      u1_vld_q <= valid_i;
      u2_vld_q <= u1_vld_q;
      u3_vld_q <= u2_vld_q;
      u4_vld_q <= u3_vld_q;
      u5_vld_q <= u4_vld_q;
      u6_vld_q <= r_vld;
      u7_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        u1_sgn_q[i] <= vec_i[i][IW-1];
        u1_m_q[i]   <= vec_i[i][IW-1] ? (~vec_i[i] + IW'(1)) : vec_i[i];
      end
      u1_side_q <= side_i;

      u2_m_q    <= u1_m_q;
      u2_sgn_q  <= u1_sgn_q;
      u2_zero_q <= (or_m == '0);
      u2_pos_q  <= pos_d;
      u2_side_q <= u1_side_q;

      u3_n_q    <= n_d;
      u3_sgn_q  <= u2_sgn_q;
      u3_zero_q <= u2_zero_q;
      u3_side_q <= u2_side_q;

      for (int i = 0; i < 3; i++) begin
        u4_sq_q[i] <= u3_n_q[i] * u3_n_q[i];
      end
      u4_n_q    <= u3_n_q;
      u4_sgn_q  <= u3_sgn_q;
      u4_zero_q <= u3_zero_q;
      u4_side_q <= u3_side_q;

      u5_sum_q  <= (2*UF+2)'(u4_sq_q[0]) + (2*UF+2)'(u4_sq_q[1]) + (2*UF+2)'(u4_sq_q[2]);
      u5_n_q    <= u4_n_q;
      u5_sgn_q  <= u4_sgn_q;
      u5_zero_q <= u4_zero_q;
      u5_side_q <= u4_side_q;

      for (int i = 0; i < 3; i++) begin
        u6_num_q[i] <= ((2*UF+1)'(r_n[i]) << UF) + (2*UF+1)'(r_len >> 1);
      end
      u6_den_q  <= r_len;
      u6_side_q <= {r_uside, r_sgn, r_zero};

      u7_unit_q <= unit_d;
      u7_side_q <= d_uside;
    end
  end

  lqa_isqrt #(
    .VW (2 * UF + 2),
    .SW (RSW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (u5_vld_q),
    .rad_i   (u5_sum_q),
    .side_i  ({u5_side_q, u5_sgn_q, u5_zero_q, u5_n_q}),
    .valid_o (r_vld),
    .root_o  (r_len),
    .side_o  (r_side)
  );

  assign {r_uside, r_sgn, r_zero, r_n} = r_side;

  lqa_div #(
    .LANES (3),
    .NW    (2 * UF + 1),
    .DW    (UF + 1),
    .QW    (UF + 1),
    .SW    (DSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (u6_vld_q),
    .num_i   (u6_num_q),
    .den_i   (u6_den_q),
    .side_i  (u6_side_q),
    .valid_o (d_vld),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  assign {d_uside, d_sgn, d_zero} = d_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_zero) begin
        unit_d[i] = '0;
      end else if (d_sgn[i]) begin
        unit_d[i] = ~{1'b0, d_quo[i]} + UW'(1);
      end else begin
        unit_d[i] = {1'b0, d_quo[i]};
      end
    end
  end

  assign valid_o = u7_vld_q;
  assign unit_o  = u7_unit_q;
  assign side_o  = u7_side_q;

endmodule

### sv/look_at_quaternion_core.sv
// Look-at rotation from origin, target and up vectors to a Q2.14 unit quaternion.
// Throughput: one word per cycle; the bit-per-stage square-root and divider pipelines
// set the depth, and the whole pipeline holds while a finished word is stalled.
// Reset: asynchronous, active low; clears the valid bits only.
module look_at_quaternion_core #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lqa_pkg::lqa_in_t  in_data_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output lqa_pkg::lqa_out_t out_data_o,
  input  logic              out_stall_i
);
  localparam int UF = lqa_pkg::UFRAC;
  localparam int UW = lqa_pkg::UW;
  localparam int SH = UF - OUT_FRAC_BITS;
  localparam int QW = SH + 16;
  localparam int PW = ((QW > UW) ? QW : UW) + 1;
  localparam logic [PW-1:0] RND = PW'((64'(1) << SH) >> 1);
  localparam logic signed [34:0] ONE = 35'sd1 <<< UF;

  function automatic logic signed [32:0] x33(input logic [31:0] v);
    x33 = {v[31], v};
  endfunction

  function automatic logic [31:0] rnd_q30(input logic [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? (~v + 64'd1) : v;
    r   = (mag + (64'd1 << (UF - 1))) >> UF;
    rnd_q30 = v[63] ? (~r[31:0] + 32'd1) : r[31:0];
  endfunction

  function automatic logic [15:0] sat_out(input logic [PW-1:0] mag, input logic neg);
    logic [PW-1:0] r;
    r = (mag + RND) >> SH;
    if (neg) begin
      sat_out = (r >= PW'(32768)) ? 16'h8000 : (~r[15:0] + 16'd1);
    end else begin
      sat_out = (r >= PW'(32767)) ? 16'h7fff : r[15:0];
    end
  endfunction

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // difference and up
  logic                a_vld_q;
  logic [2:0][32:0]    a_d_q;
  logic [2:0][31:0]    a_up_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_d_q[0] <= x33(in_data_i.origin_x) - x33(in_data_i.target_x);
      a_d_q[1] <= x33(in_data_i.origin_y) - x33(in_data_i.target_y);
      a_d_q[2] <= x33(in_data_i.origin_z) - x33(in_data_i.target_z);
      a_up_q   <= {in_data_i.up_z, in_data_i.up_y, in_data_i.up_x};
    end
  end

  logic                f_vld;
  logic [2:0][UW-1:0]  f_unit;
  logic [95:0]         f_side;
  logic [2:0][31:0]    f_up;

  lqa_unit #(
    .IW (33),
    .SW (96)
  ) u_unit_f (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (a_vld_q),
    .vec_i   (a_d_q),
    .side_i  (a_up_q),
    .valid_o (f_vld),
    .unit_o  (f_unit),
    .side_o  (f_side)
  );

  assign f_up = f_side;

  // up x forward
  logic                b_vld_q;
  logic signed [63:0]  b_p_q [6];
  logic [2:0][31:0]    b_f_q;
  logic                c_vld_q;
  logic [2:0][63:0]    c_c_q;
  logic [2:0][31:0]    c_f_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_p_q[0] <= $signed(f_up[1]) * $signed(f_unit[2]);
      b_p_q[1] <= $signed(f_up[2]) * $signed(f_unit[1]);
      b_p_q[2] <= $signed(f_up[2]) * $signed(f_unit[0]);
      b_p_q[3] <= $signed(f_up[0]) * $signed(f_unit[2]);
      b_p_q[4] <= $signed(f_up[0]) * $signed(f_unit[1]);
      b_p_q[5] <= $signed(f_up[1]) * $signed(f_unit[0]);
      b_f_q    <= f_unit;
      c_c_q[0] <= b_p_q[0] - b_p_q[1];
      c_c_q[1] <= b_p_q[2] - b_p_q[3];
      c_c_q[2] <= b_p_q[4] - b_p_q[5];
      c_f_q    <= b_f_q;
    end
  end

  logic                s_vld;
  logic [2:0][UW-1:0]  s_unit;
  logic [95:0]         s_side;
  logic [2:0][31:0]    s_f;

  lqa_unit #(
    .IW (64),
    .SW (96)
  ) u_unit_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_vld_q),
    .vec_i   (c_c_q),
    .side_i  (c_f_q),
    .valid_o (s_vld),
    .unit_o  (s_unit),
    .side_o  (s_side)
  );

  assign s_f = s_side;

  // forward x side
  logic                d_vld_q;
  logic signed [63:0]  d_p_q [6];
  logic [2:0][31:0]    d_f_q;
  logic [2:0][31:0]    d_s_q;
  logic                e_vld_q;
  logic [2:0][31:0]    e_u_q;
  logic [2:0][31:0]    e_f_q;
  logic [2:0][31:0]    e_s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_p_q[0] <= $signed(s_f[1]) * $signed(s_unit[2]);
      d_p_q[1] <= $signed(s_f[2]) * $signed(s_unit[1]);
      d_p_q[2] <= $signed(s_f[2]) * $signed(s_unit[0]);
      d_p_q[3] <= $signed(s_f[0]) * $signed(s_unit[2]);
      d_p_q[4] <= $signed(s_f[0]) * $signed(s_unit[1]);
      d_p_q[5] <= $signed(s_f[1]) * $signed(s_unit[0]);
      d_f_q    <= s_f;
      d_s_q    <= s_unit;
      e_u_q[0] <= rnd_q30(d_p_q[0] - d_p_q[1]);
      e_u_q[1] <= rnd_q30(d_p_q[2] - d_p_q[3]);
      e_u_q[2] <= rnd_q30(d_p_q[4] - d_p_q[5]);
      e_f_q    <= d_f_q;
      e_s_q    <= d_s_q;
    end
  end

  // branch select
  logic signed [34:0]  sx, uy, fz, tr, rad;
  logic signed [32:0]  na, nb, nc, pa, pb, pc;
  logic [1:0]          br_d;
  logic [2:0][32:0]    n_d;
  logic                g_vld_q;
  logic [1:0]          g_br_q;
  logic [2:0][32:0]    g_n_q;
  logic [63:0]         g_rad_q;

  always_comb begin
    sx  = {{3{e_s_q[0][31]}}, e_s_q[0]};
    uy  = {{3{e_u_q[1][31]}}, e_u_q[1]};
    fz  = {{3{e_f_q[2][31]}}, e_f_q[2]};
    tr  = sx + uy + fz;
    na  = x33(e_f_q[1]) - x33(e_u_q[2]);
    nb  = x33(e_s_q[2]) - x33(e_f_q[0]);
    nc  = x33(e_u_q[0]) - x33(e_s_q[1]);
    pa  = x33(e_f_q[1]) + x33(e_u_q[2]);
    pb  = x33(e_s_q[2]) + x33(e_f_q[0]);
    pc  = x33(e_u_q[0]) + x33(e_s_q[1]);
    if (tr > 35'sd0) begin
      br_d = lqa_pkg::BR_W;
      rad  = ONE + tr;
      n_d  = {nc, nb, na};
    end else if (sx > uy && sx > fz) begin
      br_d = lqa_pkg::BR_X;
      rad  = ONE + sx - uy - fz;
      n_d  = {pb, pc, na};
    end else if (uy > fz) begin
      br_d = lqa_pkg::BR_Y;
      rad  = ONE + uy - sx - fz;
      n_d  = {pa, nc, nb};
    end else begin
      br_d = lqa_pkg::BR_Z;
      rad  = ONE + fz - sx - uy;
      n_d  = {pa, pb, nc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_br_q  <= br_d;
      g_n_q   <= n_d;
      g_rad_q <= (rad > 35'sd0) ? (64'(rad[33:0]) << UF) : 64'd0;
    end
  end

  logic                h_vld;
  logic [31:0]         h_root;
  logic [100:0]        h_side;
  logic [1:0]          h_br;
  logic [2:0][32:0]    h_n;

  lqa_isqrt #(
    .VW (64),
    .SW (101)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_vld_q),
    .rad_i   (g_rad_q),
    .side_i  ({g_br_q, g_n_q}),
    .valid_o (h_vld),
    .root_o  (h_root),
    .side_o  (h_side)
  );

  assign {h_br, h_n} = h_side;

  // divide setup
  logic                k_vld_q;
  logic [2:0][62:0]    k_num_q;
  logic [31:0]         k_den_q;
  logic [37:0]         k_side_q;
  logic [2:0][32:0]    n_mag;
  logic [2:0]          n_sgn;
  logic [31:0]         big_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_sgn[i] = h_n[i][32];
      n_mag[i] = h_n[i][32] ? (~h_n[i] + 33'd1) : h_n[i];
    end
    big_d = 32'((33'(h_root) + 33'd1) >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        k_num_q[i] <= (63'(n_mag[i]) << (UF - 1)) + 63'(h_root >> 1);
      end
      k_den_q  <= h_root;
      k_side_q <= {h_br, n_sgn, big_d, (h_root == 32'd0)};
    end
  end

  logic                q_vld;
  logic [2:0][QW-1:0]  q_quo;
  logic [37:0]         q_side;
  logic [1:0]          q_br;
  logic [2:0]          q_sgn;
  logic [31:0]         q_big;
  logic                q_hz;

  lqa_div #(
    .LANES (3),
    .NW    (63),
    .DW    (32),
    .QW    (QW),
    .SW    (38)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (k_vld_q),
    .num_i   (k_num_q),
    .den_i   (k_den_q),
    .side_i  (k_side_q),
    .valid_o (q_vld),
    .quo_o   (q_quo),
    .side_o  (q_side)
  );

  assign {q_br, q_sgn, q_big, q_hz} = q_side;

  // assemble, round, saturate
  logic [PW-1:0]       lm [3];
  logic [2:0]          ln;
  logic [PW-1:0]       bm;
  logic [PW-1:0]       pm [4];
  logic [3:0]          pn;
  logic                out_valid_q;
  lqa_pkg::lqa_out_t   out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lm[i] = q_hz ? '0 : PW'(q_quo[i]);
      ln[i] = q_sgn[i] && !q_hz;
    end
    bm = PW'(q_big);
    case (q_br)
      lqa_pkg::BR_W: begin
        pm[0] = bm;    pm[1] = lm[0]; pm[2] = lm[1]; pm[3] = lm[2];
        pn    = {ln[2], ln[1], ln[0], 1'b0};
      end
      lqa_pkg::BR_X: begin
        pm[0] = lm[0]; pm[1] = bm;    pm[2] = lm[1]; pm[3] = lm[2];
        pn    = {ln[2], ln[1], 1'b0, ln[0]};
      end
      lqa_pkg::BR_Y: begin
        pm[0] = lm[0]; pm[1] = lm[1]; pm[2] = bm;    pm[3] = lm[2];
        pn    = {ln[2], 1'b0, ln[1], ln[0]};
      end
      default: begin
        pm[0] = lm[0]; pm[1] = lm[1]; pm[2] = lm[2]; pm[3] = bm;
        pn    = {1'b0, ln[2], ln[1], ln[0]};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      g_vld_q     <= 1'b0;
      k_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_vld_q     <= in_valid_i;
      b_vld_q     <= f_vld;
      c_vld_q     <= b_vld_q;
      d_vld_q     <= s_vld;
      e_vld_q     <= d_vld_q;
      g_vld_q     <= e_vld_q;
      k_vld_q     <= h_vld;
      out_valid_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.quat_w <= sat_out(pm[0], pn[0]);
      out_q.quat_x <= sat_out(pm[1], pn[1]);
      out_q.quat_y <= sat_out(pm[2], pn[2]);
      out_q.quat_z <= sat_out(pm[3], pn[3]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/lqa_checker.sv
// Port-level checks for the look-at quaternion core, bound to the top level.
module lqa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input lqa_pkg::lqa_in_t  in_data_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input lqa_pkg::lqa_out_t out_data_o,
  input logic              out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output word changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled input word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  a_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline is held");

endmodule

bind look_at_quaternion_core lqa_checker u_lqa_checker (.*);
